>>> hw/rtl/assert_macros.svh
// Assertion macros for the RTL files; flp_back.sv includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge while out of reset.
`define FLP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define FLP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/flp_pkg.sv
// Shared types, constants and helpers of the flash loader command parser.
package flp_pkg;

	localparam int unsigned PAGE_BYTES    = 512;
	localparam int unsigned LENGTH_DIGITS = 4;
	localparam int unsigned QUEUE_DEPTH   = 4;
	localparam int unsigned QPTR_W        = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [31:0] RESET_WINDOW_LOW  = 32'h0042_0000;
	localparam logic [31:0] RESET_WINDOW_HIGH = 32'h004F_0000;

	// configuration register indexes
	localparam logic REG_WINDOW_LOW  = 1'b0;
	localparam logic REG_WINDOW_HIGH = 1'b1;

	// command letters
	localparam logic [7:0] CMD_START  = 8'h73; // s
	localparam logic [7:0] CMD_LENGTH = 8'h6C; // l
	localparam logic [7:0] CMD_WRITE  = 8'h77; // w
	localparam logic [7:0] CMD_BOOT   = 8'h62; // b
	localparam logic [7:0] CMD_HELP   = 8'h68; // h
	localparam logic [7:0] CMD_INFO   = 8'h69; // i
	localparam logic [7:0] CMD_PROG   = 8'h70; // p

	typedef enum logic [3:0] {
		EV_START_SET  = 4'd0,
		EV_LENGTH_SET = 4'd1,
		EV_MALFORMED  = 4'd2,
		EV_BAD_START  = 4'd3,
		EV_BAD_LENGTH = 4'd4,
		EV_NO_LENGTH  = 4'd5,
		EV_ERASE      = 4'd6,
		EV_PROGRAM    = 4'd7,
		EV_WRITE_DONE = 4'd8,
		EV_BOOT       = 4'd9,
		EV_HELP       = 4'd10,
		EV_INFO       = 4'd11,
		EV_UNKNOWN    = 4'd12
	} event_t;

	typedef enum logic [3:0] {
		MODE_CMD    = 4'b0001,
		MODE_START  = 4'b0010,
		MODE_LENGTH = 4'b0100,
		MODE_DATA   = 4'b1000
	} mode_t;

	// One queue entry: the results of one byte. A second result, when present,
	// is always a write-done event.
	typedef struct packed {
		event_t      ev;
		logic [31:0] addr;
		logic [31:0] data;
		logic [7:0]  pages;
		logic        two;
		logic [31:0] done_addr;
	} entry_t;

	// {valid, value} of an ASCII hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

endpackage

>>> hw/rtl/flp_front.sv
// Front part: parses bytes, keeps parser state and window registers, pushes result entries.
module flp_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic             wr_index,
	input  logic [31:0]      wr_data,
	input  logic             take,
	input  logic [7:0]       rx_byte,
	output logic             push,
	output flp_pkg::entry_t  entry
);

	flp_pkg::mode_t mode_q, mode_d;
	logic [31:0] win_low_q, win_high_q;
	logic [3:0]  digits_q, digits_d;
	logic [31:0] accum_q, accum_d;
	logic [31:0] start_q, start_d;
	logic [15:0] length_q, length_d;
	logic [15:0] rcvd_q, rcvd_d;
	logic [23:0] word_q, word_d;

	logic [4:0]  hd;
	logic [31:0] accum_sh;
	logic [3:0]  digits_inc;
	logic [16:0] pages_full;
	logic [7:0]  pages_sat;
	logic [15:0] rcvd_inc;
	logic        emit;

	always_comb begin
		hd         = flp_pkg::hex_digit(rx_byte);
		accum_sh   = {accum_q[27:0], hd[3:0]};
		digits_inc = digits_q + 4'd1;
		pages_full = 17'(length_q / flp_pkg::PAGE_BYTES) + 17'd1;
		pages_sat  = (pages_full > 17'd255) ? 8'hFF : pages_full[7:0];
		rcvd_inc   = rcvd_q + 16'd1;
	end

	always_comb begin
		mode_d   = mode_q;
		digits_d = digits_q;
		accum_d  = accum_q;
		start_d  = start_q;
		length_d = length_q;
		rcvd_d   = rcvd_q;
		word_d   = word_q;
		emit     = 1'b0;
		entry    = '0;
		entry.ev = flp_pkg::EV_UNKNOWN;
		unique case (mode_q)
			flp_pkg::MODE_START: begin
				if (!hd[4]) begin
					start_d  = win_low_q;
					mode_d   = flp_pkg::MODE_CMD;
					emit     = 1'b1;
					entry.ev = flp_pkg::EV_MALFORMED;
				end else begin
					accum_d  = accum_sh;
					digits_d = digits_inc;
					if (digits_inc >= 4'd8) begin
						mode_d     = flp_pkg::MODE_CMD;
						emit       = 1'b1;
						entry.addr = accum_sh;
						if (accum_sh < win_low_q || accum_sh > win_high_q ||
								accum_sh[1:0] != 2'b00) begin
							start_d  = win_low_q;
							entry.ev = flp_pkg::EV_BAD_START;
						end else begin
							start_d  = accum_sh;
							entry.ev = flp_pkg::EV_START_SET;
						end
					end
				end
			end
			flp_pkg::MODE_LENGTH: begin
				if (!hd[4]) begin
					length_d = '0;
					mode_d   = flp_pkg::MODE_CMD;
					emit     = 1'b1;
					entry.ev = flp_pkg::EV_MALFORMED;
				end else begin
					accum_d  = accum_sh;
					digits_d = digits_inc;
					if (digits_inc >= 4'(flp_pkg::LENGTH_DIGITS)) begin
						mode_d     = flp_pkg::MODE_CMD;
						emit       = 1'b1;
						entry.addr = accum_sh;
						if (accum_sh == 32'd0 || accum_sh[31:16] != 16'd0 ||
								accum_sh[1:0] != 2'b00) begin
							length_d = '0;
							entry.ev = flp_pkg::EV_BAD_LENGTH;
						end else begin
							length_d = accum_sh[15:0];
							entry.ev = flp_pkg::EV_LENGTH_SET;
						end
					end
				end
			end
			flp_pkg::MODE_DATA: begin
				rcvd_d = rcvd_inc;
				if (rcvd_q[1:0] == 2'd3) begin
					emit       = 1'b1;
					entry.ev   = flp_pkg::EV_PROGRAM;
					entry.data = {rx_byte, word_q};
					entry.addr = start_q + {16'd0, rcvd_q} - 32'd3;
					word_d     = '0;
				end else begin
					case (rcvd_q[1:0])
						2'd0:    word_d[7:0]   = rx_byte;
						2'd1:    word_d[15:8]  = rx_byte;
						default: word_d[23:16] = rx_byte;
					endcase
				end
				if (rcvd_inc >= length_q) begin
					mode_d = flp_pkg::MODE_CMD;
					word_d = '0;
					if (rcvd_q[1:0] == 2'd3) begin
						entry.two       = 1'b1;
						entry.done_addr = start_q;
					end else begin
						emit       = 1'b1;
						entry.ev   = flp_pkg::EV_WRITE_DONE;
						entry.addr = start_q;
					end
				end
			end
			default: begin
				unique case (rx_byte)
					flp_pkg::CMD_START: begin
						mode_d   = flp_pkg::MODE_START;
						digits_d = '0;
						accum_d  = '0;
					end
					flp_pkg::CMD_LENGTH: begin
						mode_d   = flp_pkg::MODE_LENGTH;
						digits_d = '0;
						accum_d  = '0;
					end
					flp_pkg::CMD_WRITE: begin
						emit = 1'b1;
						if (length_q == 16'd0) begin
							entry.ev = flp_pkg::EV_NO_LENGTH;
						end else begin
							entry.ev    = flp_pkg::EV_ERASE;
							entry.addr  = start_q;
							entry.pages = pages_sat;
							mode_d      = flp_pkg::MODE_DATA;
							rcvd_d      = '0;
							word_d      = '0;
						end
					end
					flp_pkg::CMD_BOOT: begin
						emit     = 1'b1;
						entry.ev = flp_pkg::EV_BOOT;
					end
					flp_pkg::CMD_HELP: begin
						emit     = 1'b1;
						entry.ev = flp_pkg::EV_HELP;
					end
					flp_pkg::CMD_INFO: begin
						emit     = 1'b1;
						entry.ev = flp_pkg::EV_INFO;
					end
					flp_pkg::CMD_PROG: begin
						emit = 1'b0;
					end
					default: begin
						emit     = 1'b1;
						entry.ev = flp_pkg::EV_UNKNOWN;
					end
				endcase
			end
		endcase
		push = take && emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= flp_pkg::MODE_CMD;
			digits_q <= '0;
			accum_q  <= '0;
			start_q  <= flp_pkg::RESET_WINDOW_LOW;
			length_q <= '0;
			rcvd_q   <= '0;
			word_q   <= '0;
		end else if (take) begin
			mode_q   <= mode_d;
			digits_q <= digits_d;
			accum_q  <= accum_d;
			start_q  <= start_d;
			length_q <= length_d;
			rcvd_q   <= rcvd_d;
			word_q   <= word_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_low_q  <= flp_pkg::RESET_WINDOW_LOW;
			win_high_q <= flp_pkg::RESET_WINDOW_HIGH;
		end else if (wr_en) begin
			if (wr_index == flp_pkg::REG_WINDOW_LOW) win_low_q <= wr_data;
			if (wr_index == flp_pkg::REG_WINDOW_HIGH) win_high_q <= wr_data;
		end
	end

endmodule

>>> hw/rtl/flp_back.sv
// Back part: result queue and output register that splits double entries.
`include "assert_macros.svh"
module flp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  flp_pkg::entry_t  entry,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [3:0]       event_res,
	output logic [31:0]      address,
	output logic [31:0]      data_word,
	output logic [7:0]       page_count,
	output logic             last
);

	flp_pkg::entry_t queue_q [flp_pkg::QUEUE_DEPTH];
	logic [flp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [flp_pkg::QCNT_W-1:0] count_q;
	logic            sub_q;
	logic            valid_q;
	flp_pkg::entry_t head;
	logic            load, pop;

	always_comb begin
		head = queue_q[rd_ptr_q];
		full = (count_q == flp_pkg::QCNT_W'(flp_pkg::QUEUE_DEPTH));
		load = (!valid_q || !out_stall) && (count_q != '0);
		pop  = load && (!head.two || sub_q);
	end

	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			sub_q    <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + flp_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + flp_pkg::QPTR_W'(1);
			if (push && !pop) count_q <= count_q + flp_pkg::QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - flp_pkg::QCNT_W'(1);
			if (load) sub_q <= head.two && !sub_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (sub_q) begin
				event_res  <= flp_pkg::EV_WRITE_DONE;
				address    <= head.done_addr;
				data_word  <= '0;
				page_count <= '0;
				last       <= 1'b1;
			end else begin
				event_res  <= head.ev;
				address    <= head.addr;
				data_word  <= head.data;
				page_count <= head.pages;
				last       <= !head.two;
			end
		end
	end

	assign out_valid = valid_q;

	`FLP_ASSERT_ALWAYS(a_count_bound, count_q <= flp_pkg::QCNT_W'(flp_pkg::QUEUE_DEPTH), "queue count over depth")
	`FLP_ASSERT(a_sub_has_entry, sub_q |-> count_q != '0, "second half pending with empty queue")
	`FLP_ASSERT(a_no_push_full, push |-> !full, "push into full queue")
	`FLP_ASSERT(a_sub_after_two, $rose(sub_q) |-> $past(load) && $past(head.two), "split without double entry")

endmodule

>>> hw/rtl/flash_loader_command_parser.sv
// Top level of the flash loader command parser: front parser plus back result queue.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------------------
//   in      | input     | in_valid/in_stall   | rx_byte
//   out     | output    | out_valid/out_stall | event_res, address, data_word, page_count, last
//   wr      | input     | wr_en               | wr_index, wr_data
//
// One byte is taken per cycle while in_stall is low; the parser state updates in the accepting cycle.
// A result passes through the result queue and then the output register before it appears at the output.
// A byte that yields two results occupies the output for two handshakes, the write-done result second.
// in_stall rises only while the four-entry result queue is full.
// arst_n clears parser state, queue pointers and out_valid; windows reset to defaults.
module flash_loader_command_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [31:0] wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  event_res,
	output logic [31:0] address,
	output logic [31:0] data_word,
	output logic [7:0]  page_count,
	output logic        last
);

	logic            full;
	logic            take;
	logic            push;
	flp_pkg::entry_t entry;

	// Accept an item whenever the queue has room for its results.
	assign in_stall = full;
	assign take     = in_valid && !full;

	// Front: decode the byte, advance parser state, emit an entry when results exist.
	flp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.take     (take),
		.rx_byte  (rx_byte),
		.push     (push),
		.entry    (entry)
	);

	// Back: hold entries, drive one result per output handshake.
	flp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.entry      (entry),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_res  (event_res),
		.address    (address),
		.data_word  (data_word),
		.page_count (page_count),
		.last       (last)
	);

endmodule
